/* hw/rtl/fejdi_pkg.sv */
// Package for the 3x3 Jacobian determinant and inverse block.
// Holds shared widths, controller/datapath types and index tables.
// No dependencies.
package fejdi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = 64;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_W     = VAL_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    PH_NONE,
    PH_ACC,
    PH_ADJ,
    PH_DET
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_ACC_WAIT,
    ST_ADJ,
    ST_DET,
    ST_DET_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // Command from controller to datapath
  typedef struct packed {
    phase_t     phase;
    logic [4:0] step;
    logic       load_in;
    logic       clear;
    logic       div_start;
    logic [3:0] idx;
    logic [1:0] row;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sing;
    logic div_done;
  } status_t;

  // Row of a Jacobian entry index
  function automatic logic [1:0] row_of(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Column of a Jacobian entry index
  function automatic logic [1:0] col_of(input logic [3:0] k);
    logic [1:0] c;
    case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Jacobian indices for adj[e] = J[a]*J[b] - J[c]*J[d], packed {a,b,c,d}
  function automatic logic [15:0] adj_terms(input logic [3:0] e);
    logic [15:0] t;
    case (e)
      4'd0:    t = {4'd4, 4'd8, 4'd7, 4'd5};
      4'd1:    t = {4'd2, 4'd7, 4'd1, 4'd8};
      4'd2:    t = {4'd1, 4'd5, 4'd2, 4'd4};
      4'd3:    t = {4'd5, 4'd6, 4'd3, 4'd8};
      4'd4:    t = {4'd0, 4'd8, 4'd2, 4'd6};
      4'd5:    t = {4'd3, 4'd2, 4'd0, 4'd5};
      4'd6:    t = {4'd3, 4'd7, 4'd6, 4'd4};
      4'd7:    t = {4'd6, 4'd1, 4'd0, 4'd7};
      default: t = {4'd0, 4'd4, 4'd3, 4'd1};
    endcase
    return t;
  endfunction

endpackage

/* hw/rtl/fejdi_div.sv */
// Iterative signed divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Depends on fejdi_pkg.
module fejdi_div import fejdi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] num,
  input  logic signed [VAL_W-1:0] den,
  output logic                    done,
  output logic signed [VAL_W-1:0] quot
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] qsh;
  logic [VAL_W:0]   rem;
  logic [VAL_W-1:0] dmag;
  logic             neg;
  logic [VAL_W-1:0] nmag;
  logic [VAL_W:0]   rem_sh;
  logic [VAL_W:0]   rem_sub;
  logic [NUM_W-1:0] q_next;
  logic [NUM_W:0]   lim;

  assign nmag    = num[VAL_W-1] ? VAL_W'(-num) : VAL_W'(num);
  assign rem_sh  = {rem[VAL_W-1:0], qsh[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dmag};
  assign q_next  = {qsh[NUM_W-2:0], ~rem_sub[VAL_W]};

  // Shift-subtract one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        qsh  <= {nmag, {FRAC_BITS{1'b0}}};
        rem  <= '0;
        dmag <= den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
        neg  <= num[VAL_W-1] ^ den[VAL_W-1];
      end else if (busy) begin
        qsh <= q_next;
        rem <= rem_sub[VAL_W] ? rem_sh : rem_sub;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    lim = {1'b0, qsh};
    if (neg) begin
      if (lim > (NUM_W+1)'(64'h8000_0000)) quot = {1'b1, {(VAL_W-1){1'b0}}};
      else                                  quot = VAL_W'(-lim);
    end else begin
      if (lim > (NUM_W+1)'(64'h7FFF_FFFF)) quot = {1'b0, {(VAL_W-1){1'b1}}};
      else                                  quot = VAL_W'(lim);
    end
  end

endmodule

/* hw/rtl/fejdi_datapath.sv */
// Datapath: input registers, accumulators, one shared multiplier, adjugate,
// determinant, inverse storage and row output select. Depends on fejdi_pkg, fejdi_div.
module fejdi_datapath import fejdi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [6*VAL_W-1:0]         in_data,
  output logic [7*VAL_W+2:0]         row_data
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [VAL_W-1:0]  grad [3];
  logic signed [VAL_W-1:0]  coord [3];
  logic signed [ACC_W-1:0]  acc [9];
  logic signed [VAL_W-1:0]  jac [9];
  logic signed [VAL_W-1:0]  adj [9];
  logic signed [VAL_W-1:0]  inv [9];
  logic signed [VAL_W-1:0]  det;
  logic signed [VAL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_tot;
  logic signed [SUM_W-1:0]  term;
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [VAL_W-1:0]  rnd_val;
  logic signed [SUM_W-1:0]  rnd_sh;
  logic signed [ACC_W-1:0]  acc_new;
  cmd_t                     cmd_q;
  logic [15:0]              terms;
  logic [3:0]               sel_a, sel_b;
  logic                     div_done;
  logic signed [VAL_W-1:0]  div_q;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SUM_W'(SMAX))      r = SMAX;
    else if (v < SUM_W'(SMIN)) r = SMIN;
    else                       r = VAL_W'(v);
    return r;
  endfunction

  // Saturated Jacobian view of the accumulators
  always_comb begin
    for (int k = 0; k < 9; k++) jac[k] = sat32(SUM_W'(acc[k]));
  end

  // Select multiplier operands for the current step
  always_comb begin
    terms = adj_terms(cmd.step[4:1]);
    sel_a = '0;
    sel_b = '0;
    op_a  = '0;
    op_b  = '0;
    case (cmd.phase)
      PH_ACC: begin
        op_a = coord[row_of(cmd.step[3:0])];
        op_b = grad[col_of(cmd.step[3:0])];
      end
      PH_ADJ: begin
        sel_a = cmd.step[0] ? terms[7:4] : terms[15:12];
        sel_b = cmd.step[0] ? terms[3:0] : terms[11:8];
        op_a  = jac[sel_a];
        op_b  = jac[sel_b];
      end
      PH_DET: begin
        op_a = jac[cmd.step[3:0]];
        op_b = adj[{cmd.step[1:0], 1'b0} + {2'b00, cmd.step[1:0]}];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Writeback arithmetic on the registered product
  always_comb begin
    term = SUM_W'(prod);
    if (cmd_q.phase == PH_ADJ && cmd_q.step[0]) sum_tot = sum - term;
    else if (cmd_q.phase == PH_DET && cmd_q.step != 5'd0) sum_tot = sum + term;
    else sum_tot = term;
    rnd_sh  = (sum_tot + HALF) >>> FRAC_BITS;
    rnd_val = sat32(rnd_sh);
    acc_sum = SUM_W'(acc[cmd_q.step[3:0]]) + ((term + HALF) >>> FRAC_BITS);
    if (acc_sum > SUM_W'(AMAX))      acc_new = AMAX;
    else if (acc_sum < SUM_W'(AMIN)) acc_new = AMIN;
    else                             acc_new = ACC_W'(acc_sum);
  end

  // Multiply stage and writeback stage
  always_ff @(posedge clk) begin
    prod  <= op_a * op_b;
    cmd_q <= cmd;
    sum   <= sum_tot;
    if (cmd.load_in) begin
      for (int i = 0; i < 3; i++) begin
        grad[i]  <= in_data[i*VAL_W +: VAL_W];
        coord[i] <= in_data[(i+3)*VAL_W +: VAL_W];
      end
    end
    if (cmd_q.phase == PH_ADJ && cmd_q.step[0]) adj[cmd_q.step[4:1]] <= rnd_val;
    if (cmd_q.phase == PH_DET && cmd_q.step == 5'd2) det <= rnd_val;
    if (div_done) inv[cmd.idx] <= div_q;
  end

  // Accumulators: clear on reset and after the last row
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int k = 0; k < 9; k++) acc[k] <= '0;
    end else if (cmd_q.phase == PH_ACC) begin
      acc[cmd_q.step[3:0]] <= acc_new;
    end
  end

  fejdi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (adj[cmd.idx]),
    .den   (det),
    .done  (div_done),
    .quot  (div_q)
  );

  assign status.sing     = (det == '0);
  assign status.div_done = div_done;

  // Output row: row_index, jac x3, inv x3, det, singular
  always_comb begin
    logic [3:0] b;
    b = {cmd.row, 1'b0} + {2'b00, cmd.row};
    row_data = {status.sing, det,
                status.sing ? VAL_W'(0) : inv[b + 4'd2],
                status.sing ? VAL_W'(0) : inv[b + 4'd1],
                status.sing ? VAL_W'(0) : inv[b],
                jac[b + 4'd2], jac[b + 4'd1], jac[b], cmd.row};
  end

endmodule

/* hw/rtl/fejdi_ctrl.sv */
// Controller state machine: sequences accumulate, adjugate, determinant,
// divide and row output. Depends on fejdi_pkg.
module fejdi_ctrl import fejdi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    s_tlast,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic    m_tlast,
  output cmd_t    cmd,
  input  status_t status
);

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic [3:0] idx, idx_next;
  logic [1:0] row, row_next;
  logic       last_q, last_q_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      idx    <= '0;
      row    <= '0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      idx    <= idx_next;
      row    <= row_next;
      last_q <= last_q_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_next     = step;
    idx_next      = idx;
    row_next      = row;
    last_q_next   = last_q;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    m_tlast       = 1'b0;
    cmd.phase     = PH_NONE;
    cmd.step      = step;
    cmd.load_in   = 1'b0;
    cmd.clear     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.idx       = idx;
    cmd.row       = row;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          last_q_next = s_tlast;
          step_next   = '0;
          state_next  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.phase = PH_ACC;
        step_next = step + 5'd1;
        if (step == 5'd8) state_next = ST_ACC_WAIT;
      end
      ST_ACC_WAIT: begin
        step_next  = '0;
        state_next = last_q ? ST_ADJ : ST_IDLE;
      end
      ST_ADJ: begin
        cmd.phase = PH_ADJ;
        step_next = step + 5'd1;
        if (step == 5'd17) begin
          step_next  = '0;
          state_next = ST_DET;
        end
      end
      ST_DET: begin
        cmd.phase = PH_DET;
        step_next = step + 5'd1;
        if (step == 5'd2) state_next = ST_DET_WAIT;
      end
      ST_DET_WAIT: begin
        // Wait for the determinant writeback, then decide from the registered value
        step_next = step + 5'd1;
        if (step == 5'd4) begin
          idx_next   = '0;
          row_next   = '0;
          state_next = status.sing ? ST_OUT : ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          idx_next   = idx + 4'd1;
          state_next = (idx == 4'd8) ? ST_OUT : ST_DIV_START;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        m_tlast  = (row == 2'd2);
        if (m_tready) begin
          row_next = row + 2'd1;
          if (row == 2'd2) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/fe_jacobian_det_inverse_3d.sv */
// Top level of the 3x3 Jacobian determinant and inverse block.
// Depends on fejdi_pkg, fejdi_ctrl, fejdi_datapath.
//
// Usage: send one word per element node on the s_ side; s_tlast marks the
// last node of a quadrature point. Each node is folded in as nine
// coordinate-gradient products through one shared 32x32 multiplier, between
// a load and a drain step. After the last node the block computes the
// adjugate and then the determinant through the same multiplier, then each
// of the nine inverse entries in a bit-serial divider (skipped when the
// determinant is zero).
// Three row words then leave on the m_ side, m_tlast on the third.
// s_tready is low from acceptance until the node is folded in, and through
// the whole finish phase until the third row word is taken.
// If the receiver stalls, the current row word holds on m_tdata and the
// block waits. Reset clears the controller and the accumulators; no word
// is in flight afterwards.
module fe_jacobian_det_inverse_3d import fejdi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // grad_r, grad_s, grad_t, coord_x, coord_y, coord_z
  input  logic         s_tlast,  // last_node
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [231:0] m_tdata,  // row_index, jac_col0..2, inv_col0..2, determinant,
                                 // singular, zero fill
  output logic         m_tlast   // last_row
);

  cmd_t              cmd;
  status_t           status;
  logic [7*VAL_W+2:0] row_data;

  fejdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

  fejdi_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .row_data (row_data)
  );

  // Pad the row word to whole bytes
  assign m_tdata = {5'b0, row_data};

endmodule
